>>> design/twis_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twis_pkg
// Shared types, constants and helpers of the trie word insert/search unit.
// ----------------------------------------------------------------------------
package twis_pkg;

  localparam int unsigned AlphabetSize  = 26;
  localparam int unsigned NodeCountDef  = 4096;
  localparam int unsigned LetterWidth   = 8;
  localparam int unsigned ValueWidth    = 16;
  localparam int unsigned StatusWidth   = 3;
  localparam int unsigned IndexWidth    = 5;

  localparam logic [LetterWidth-1:0] CharUpperA = 8'h41;
  localparam logic [LetterWidth-1:0] CharUpperZ = 8'h5A;
  localparam logic [LetterWidth-1:0] CharLowerA = 8'h61;
  localparam logic [LetterWidth-1:0] CharLowerZ = 8'h7A;
  localparam logic [LetterWidth-1:0] CaseOffset = 8'h20;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_SEARCH = 1'b1
  } opcode_e;

  typedef enum logic [StatusWidth-1:0] {
    ST_FOUND     = 3'd0,
    ST_NO_PATH   = 3'd1,
    ST_NO_END    = 3'd2,
    ST_INSERTED  = 3'd3,
    ST_POOL_FULL = 3'd4,
    ST_BAD_CHAR  = 3'd5
  } status_e;

  typedef struct packed {
    logic                  bad;
    logic [IndexWidth-1:0] idx;
  } letter_t;

  // Folds upper case to lower case and maps a..z onto 0..25.
  function automatic letter_t decode_letter(logic [LetterWidth-1:0] ch);
    logic [LetterWidth-1:0] c;
    logic [LetterWidth-1:0] diff;
    letter_t                res;
    c = ch;
    if (c >= CharUpperA && c <= CharUpperZ) begin
      c = c + CaseOffset;
    end
    diff    = c - CharLowerA;
    res.bad = !(c >= CharLowerA && c <= CharLowerZ);
    res.idx = diff[IndexWidth-1:0];
    return res;
  endfunction

endpackage

>>> design/twis_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twis_ram
// Simple dual-port synchronous RAM: one write and one registered read a cycle.
// ----------------------------------------------------------------------------
module twis_ram #(
  parameter int unsigned Depth = 4096,
  parameter int unsigned Width = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/trie_word_insert_search_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trie_word_insert_search_unit
// 26-way trie over a node pool: inserts and looks up words one letter a time.
// ----------------------------------------------------------------------------
// Input channel (s_axis): one character per item. tdata carries the letter
// and the value to store, tuser the opcode (insert or search), tlast marks
// the final character of a word. Letters are folded to lower case.
// Output channel (m_axis): one item per word, after its final character,
// carrying the status and the value found by a search.
// Each node owns one row of child pointers in a pool memory and one word-end
// value in a second memory. For each character the child pointer row of the
// current node is read in the accept cycle and resolved in the next, and the
// following character needs that pointer, so no new character is taken until
// the last one is resolved. The final character adds a step that reads or
// writes the word-end value; the result is registered at the end of that step,
// which waits while the output register still holds an untaken result.
// After reset the unit clears the root node in its init state before it
// accepts items. New nodes are cleared when they are allocated.
// If the receiver stalls, the finished result waits in the output register;
// the unit keeps accepting characters and holds only when a further result
// is ready while the previous one has not been taken.
// ----------------------------------------------------------------------------
module trie_word_insert_search_unit #(
  parameter int unsigned NodeCount = twis_pkg::NodeCountDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [7:0] letter, [23:8] word_value
  input  logic        s_axis_tuser,   // [0] opcode
  input  logic        s_axis_tlast,   // last_char
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // [2:0] status, [18:3] found_value, rest zero
);

  import twis_pkg::*;

  localparam int unsigned PtrWidth  = $clog2(NodeCount);
  localparam int unsigned FreeWidth = $clog2(NodeCount + 1);
  localparam int unsigned RowWidth  = AlphabetSize * PtrWidth;

  typedef enum logic [1:0] {
    S_INIT,
    S_IDLE,
    S_WALK,
    S_FINAL
  } state_e;

  state_e                 state_q, state_d;
  opcode_e                op_q, op_d;
  logic [IndexWidth-1:0]  idx_q, idx_d;
  logic                   bad_q, bad_d;
  logic                   last_q, last_d;
  logic [ValueWidth-1:0]  value_q, value_d;
  logic [PtrWidth-1:0]    cur_q, cur_d;
  logic [FreeWidth-1:0]   free_q, free_d;
  logic                   missed_q, missed_d;
  status_e                err_q, err_d;        // ST_FOUND stands for no error held
  logic                   fresh_q, fresh_d;    // current node was just allocated
  logic                   zpend_q, zpend_d;
  logic [PtrWidth-1:0]    zaddr_q, zaddr_d;
  logic                   out_valid_q, out_valid_d;
  status_e                out_status_q, out_status_d;
  logic [ValueWidth-1:0]  out_value_q, out_value_d;

  logic                   child_we;
  logic [PtrWidth-1:0]    child_waddr;
  logic [RowWidth-1:0]    child_wdata;
  logic [RowWidth-1:0]    child_rdata;
  logic                   end_we;
  logic [PtrWidth-1:0]    end_waddr;
  logic [ValueWidth-1:0]  end_wdata;
  logic [ValueWidth-1:0]  end_rdata;

  logic [RowWidth-1:0]    row;
  logic [RowWidth-1:0]    new_row;
  logic [PtrWidth-1:0]    child;
  logic                   can_alloc;
  logic [ValueWidth-1:0]  end_value;
  logic                   accept;
  logic                   out_free;
  letter_t                in_letter;

  twis_ram #(
    .Depth (NodeCount),
    .Width (RowWidth)
  ) u_child_ram (
    .clk_i   (clk_i),
    .we_i    (child_we),
    .waddr_i (child_waddr),
    .wdata_i (child_wdata),
    .raddr_i (cur_q),
    .rdata_o (child_rdata)
  );

  twis_ram #(
    .Depth (NodeCount),
    .Width (ValueWidth)
  ) u_end_ram (
    .clk_i   (clk_i),
    .we_i    (end_we),
    .waddr_i (end_waddr),
    .wdata_i (end_wdata),
    .raddr_i (cur_d),
    .rdata_o (end_rdata)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign in_letter     = decode_letter(s_axis_tdata[7:0]);

  // A freshly allocated node reads as empty while its clearing write is in flight.
  assign row       = fresh_q ? '0 : child_rdata;
  assign child     = row[idx_q*PtrWidth +: PtrWidth];
  assign can_alloc = free_q < FreeWidth'(NodeCount);
  assign end_value = fresh_q ? '0 : end_rdata;

  always_comb begin
    for (int i = 0; i < AlphabetSize; i++) begin
      new_row[i*PtrWidth +: PtrWidth] = (IndexWidth'(i) == idx_q) ?
                                        free_q[PtrWidth-1:0] :
                                        row[i*PtrWidth +: PtrWidth];
    end
  end

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    idx_d        = idx_q;
    bad_d        = bad_q;
    last_d       = last_q;
    value_d      = value_q;
    cur_d        = cur_q;
    free_d       = free_q;
    missed_d     = missed_q;
    err_d        = err_q;
    fresh_d      = fresh_q;
    zpend_d      = 1'b0;
    zaddr_d      = zaddr_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_status_d = out_status_q;
    out_value_d  = out_value_q;
    child_we     = zpend_q;
    child_waddr  = zaddr_q;
    child_wdata  = '0;
    end_we       = 1'b0;
    end_waddr    = cur_q;
    end_wdata    = '0;

    unique case (state_q)
      S_INIT: begin
        child_we    = 1'b1;
        child_waddr = '0;
        end_we      = 1'b1;
        end_waddr   = '0;
        state_d     = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          op_d    = opcode_e'(s_axis_tuser);
          idx_d   = in_letter.idx;
          bad_d   = in_letter.bad;
          last_d  = s_axis_tlast;
          value_d = s_axis_tdata[23:8];
          state_d = S_WALK;
        end
      end
      S_WALK: begin
        if (bad_q) begin
          if (err_q == ST_FOUND) begin
            err_d = ST_BAD_CHAR;
          end
        end else if (err_q == ST_FOUND && !missed_q) begin
          if (child == '0) begin
            if (op_q == OP_SEARCH) begin
              missed_d = 1'b1;
            end else if (can_alloc) begin
              child_we    = 1'b1;
              child_waddr = cur_q;
              child_wdata = new_row;
              end_we      = 1'b1;
              end_waddr   = free_q[PtrWidth-1:0];
              zpend_d     = 1'b1;
              zaddr_d     = free_q[PtrWidth-1:0];
              cur_d       = free_q[PtrWidth-1:0];
              fresh_d     = 1'b1;
              free_d      = free_q + FreeWidth'(1);
            end else begin
              err_d = ST_POOL_FULL;
            end
          end else begin
            cur_d   = child;
            fresh_d = 1'b0;
          end
        end
        state_d = last_q ? S_FINAL : S_IDLE;
      end
      S_FINAL: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_value_d = '0;
          if (err_q != ST_FOUND) begin
            out_status_d = err_q;
          end else if (op_q == OP_INSERT) begin
            out_status_d = ST_INSERTED;
            end_we       = 1'b1;
            end_waddr    = cur_q;
            end_wdata    = value_q;
          end else if (missed_q) begin
            out_status_d = ST_NO_PATH;
          end else if (end_value != '0) begin
            out_status_d = ST_FOUND;
            out_value_d  = end_value;
          end else begin
            out_status_d = ST_NO_END;
          end
          cur_d    = '0;
          missed_d = 1'b0;
          err_d    = ST_FOUND;
          fresh_d  = 1'b0;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_INIT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      cur_q       <= '0;
      free_q      <= FreeWidth'(1);
      missed_q    <= 1'b0;
      err_q       <= ST_FOUND;
      fresh_q     <= 1'b0;
      zpend_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cur_q       <= cur_d;
      free_q      <= free_d;
      missed_q    <= missed_d;
      err_q       <= err_d;
      fresh_q     <= fresh_d;
      zpend_q     <= zpend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    idx_q        <= idx_d;
    bad_q        <= bad_d;
    last_q       <= last_d;
    value_q      <= value_d;
    zaddr_q      <= zaddr_d;
    out_status_q <= out_status_d;
    out_value_q  <= out_value_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b0, out_value_q, out_status_q};

  // The free counter stays within the pool and never hands out the root.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_q != '0 && free_q <= FreeWidth'(NodeCount))
    else $error("free node counter out of range");

  // The walk only ever stands on a node that has been allocated.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    FreeWidth'(cur_q) < free_q)
    else $error("current node not allocated");

  // A pending node clear never collides with a pointer update.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(zpend_q && state_q == S_WALK))
    else $error("node clear overlaps a walk write");

  // A new result only appears after a word has been finished.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_FINAL))
    else $error("result without a finished word");

endmodule
